>>> rtl/core/rna_pkg.sv
`timescale 1ns / 1ps

package rna_pkg;

	localparam int MAX_AGENTS = 64;
	localparam int AGENT_W = $clog2(MAX_AGENTS);
	localparam int CNT_W = AGENT_W + 1;
	localparam int DATA_W = 16;
	localparam int IDX_W = 6;
	localparam int NCOUNT_W = 6;
	localparam int NCOUNT_MAX = (1 << NCOUNT_W) - 1;
	localparam int SUM_W = DATA_W + AGENT_W;
	localparam int REM_W = CNT_W + 1;
	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int RADIUS_W = 33;
	localparam int ACOUNT_W = 7;
	localparam int SQ_W = 2 * DATA_W + 1;
	localparam int ENTRY_W = 4 * DATA_W;
	localparam int FIELDS_W = IDX_W + ENTRY_W;
	localparam int TDATA_W = ((FIELDS_W + 7) / 8) * 8;
	localparam int PAD_W = TDATA_W - FIELDS_W;
	localparam int CFG_DATA_W = RADIUS_W;

	localparam logic [RADIUS_W-1:0] RADIUS_SQ_RESET = RADIUS_W'(409600);
	localparam logic [ACOUNT_W-1:0] AGENT_COUNT_RESET = ACOUNT_W'(50);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic {
		REG_RADIUS_SQ = 1'b0,
		REG_AGENT_COUNT = 1'b1
	} cfg_reg_t;

	typedef logic signed [DATA_W-1:0] val_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		val_t vel_y;
		val_t vel_x;
		val_t pos_y;
		val_t pos_x;
	} entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		sum_t vel_y;
		sum_t vel_x;
		sum_t pos_y;
		sum_t pos_x;
	} acc_t;

endpackage

>>> rtl/core/radius_neighbor_average.sv
`timescale 1ns / 1ps
// channel  dir  handshake                 payload
// s        in   s_tvalid / s_tready       s_tuser: operation; s_tdata: entry or query index
// m        out  m_tvalid / m_tready       m_tdata: neighbor count and four means
// cfg      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// a write request goes straight into the table; a query reads table entries 0 up to
// agent_count - 1, at most the full table: one table read per cycle through the
// single ram read port, then a four-lane shift-subtract divider for the four means,
// one quotient bit a cycle; the divider is skipped when no neighbor is found
// s_tready is low while a query runs; the finished result waits in the output register
// cfg_ready is always high; reset sets radius_squared to 409600 and agent_count to 50

module radius_neighbor_average import rna_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_W-1:0]    s_tdata,    // agent_index, pos_x, pos_y, vel_x, vel_y
	input  logic                  s_tuser,    // operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,    // neighbor_count, mean_pos_x, mean_pos_y,
	                                          // mean_vel_x, mean_vel_y
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CENTER = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DIVIDE = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	logic [RADIUS_W-1:0] radius_sq_q;
	logic [ACOUNT_W-1:0] agent_count_q;
	logic [AGENT_W-1:0] idx_q;
	logic [CNT_W-1:0] issue_i_q, limit_q;
	logic rd_vld_s1, rd_self_s1;
	logic m_tvalid_q;
	logic [NCOUNT_W-1:0] out_count_q;
	entry_t out_mean_q;

	logic [IDX_W-1:0] in_idx;
	entry_t in_ent;
	logic in_range, s_fire, cfg_fire, issuing, div_start, scan_busy, div_done, drained;
	logic [AGENT_W-1:0] in_addr, rd_addr;
	logic [CNT_W-1:0] limit_d;
	entry_t rd_data, div_mean;
	acc_t acc;

	assign in_idx = s_tdata[IDX_W-1:0];
	assign in_ent = s_tdata[FIELDS_W-1:IDX_W];
	assign in_range = (32'(in_idx) < MAX_AGENTS);
	assign in_addr = AGENT_W'(32'(in_idx));
	assign s_tready = (state_q == ST_IDLE);
	assign s_fire = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign limit_d = (32'(agent_count_q) > MAX_AGENTS) ? CNT_W'(MAX_AGENTS)
		: CNT_W'(agent_count_q);
	assign issuing = ((state_q == ST_CENTER) || (state_q == ST_SCAN)) && (issue_i_q < limit_q);
	assign rd_addr = (state_q == ST_IDLE) ? in_addr : issue_i_q[AGENT_W-1:0];
	assign drained = !issuing && !rd_vld_s1 && !scan_busy;
	assign div_start = (state_q == ST_SCAN) && drained && (acc.count != '0);

	rna_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_AGENTS)
	) u_table (
		.clk    (clk),
		.wr_en  (s_fire && (s_tuser == OP_WRITE) && in_range),
		.wr_addr(in_addr),
		.wr_data(in_ent),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	rna_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (s_fire),
		.center_load(state_q == ST_CENTER),
		.ent_vld    (rd_vld_s1 && !rd_self_s1),
		.ent        (rd_data),
		.radius_sq  (radius_sq_q),
		.busy       (scan_busy),
		.acc        (acc)
	);

	rna_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.acc   (acc),
		.done  (div_done),
		.mean  (div_mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_sq_q <= RADIUS_SQ_RESET;
			agent_count_q <= AGENT_COUNT_RESET;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_RADIUS_SQ: radius_sq_q <= cfg_data[RADIUS_W-1:0];
				REG_AGENT_COUNT: agent_count_q <= cfg_data[ACOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_i_q <= '0;
			rd_vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issuing;
			if (issuing) begin
				issue_i_q <= issue_i_q + CNT_W'(1);
			end
			if ((state_q == ST_FINISH) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire && (s_tuser == OP_QUERY)) begin
						issue_i_q <= '0;
						state_q <= in_range ? ST_CENTER : ST_FINISH;
					end
				end
				ST_CENTER: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (drained) begin
						state_q <= (acc.count != '0) ? ST_DIVIDE : ST_FINISH;
					end
				end
				ST_DIVIDE: begin
					if (div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			idx_q <= in_addr;
			limit_q <= limit_d;
		end
		rd_self_s1 <= (issue_i_q[AGENT_W-1:0] == idx_q);
		if ((state_q == ST_FINISH) && (!m_tvalid_q || m_tready)) begin
			out_count_q <= (32'(acc.count) > NCOUNT_MAX) ? NCOUNT_W'(NCOUNT_MAX)
				: NCOUNT_W'(acc.count);
			out_mean_q <= (acc.count == '0) ? '0 : div_mean;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{PAD_W{1'b0}}, out_mean_q, out_count_q};

	a_zero_means: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && (out_count_q == '0)) |-> (out_mean_q == '0))
		else $error("nonzero mean with no neighbors");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (acc.count != '0))
		else $error("divide started with zero divisor");

	a_div_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> (!rd_vld_s1 && !scan_busy))
		else $error("scan still in flight during divide");

	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (s_tuser == OP_QUERY)) |=> ((state_q == ST_CENTER) || (state_q == ST_FINISH)))
		else $error("query did not start a scan");

endmodule

>>> rtl/core/rna_ram.sv
`timescale 1ns / 1ps

module rna_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/core/rna_scan.sv
`timescale 1ns / 1ps

module rna_scan import rna_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  logic                center_load,
	input  logic                ent_vld,
	input  entry_t              ent,
	input  logic [RADIUS_W-1:0] radius_sq,
	output logic                busy,
	output acc_t                acc
);

	val_t cx_q, cy_q;
	logic vld_s2;
	logic [SQ_W-1:0] sqx_s2, sqy_s2;
	entry_t ent_s2;
	logic [CNT_W-1:0] count_q;
	sum_t pos_x_q, pos_y_q, vel_x_q, vel_y_q;

	logic signed [DATA_W:0] dx, dy;
	logic signed [SQ_W-1:0] px, py;
	logic [SQ_W:0] d2;
	logic hit;

	always_comb begin
		dx = {ent.pos_x[DATA_W-1], ent.pos_x} - {cx_q[DATA_W-1], cx_q};
		dy = {ent.pos_y[DATA_W-1], ent.pos_y} - {cy_q[DATA_W-1], cy_q};
		px = dx * dx;
		py = dy * dy;
		d2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		hit = vld_s2 && (d2 < {{(SQ_W + 1 - RADIUS_W){1'b0}}, radius_sq});
	end

	always_ff @(posedge clk) begin
		if (center_load) begin
			cx_q <= ent.pos_x;
			cy_q <= ent.pos_y;
		end
		sqx_s2 <= px;
		sqy_s2 <= py;
		ent_s2 <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			count_q <= '0;
		end else if (clear) begin
			vld_s2 <= 1'b0;
			count_q <= '0;
		end else begin
			vld_s2 <= ent_vld;
			if (hit) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
		end else if (hit) begin
			pos_x_q <= pos_x_q + SUM_W'(ent_s2.pos_x);
			pos_y_q <= pos_y_q + SUM_W'(ent_s2.pos_y);
			vel_x_q <= vel_x_q + SUM_W'(ent_s2.vel_x);
			vel_y_q <= vel_y_q + SUM_W'(ent_s2.vel_y);
		end
	end

	assign busy = vld_s2;
	assign acc = {count_q, vel_y_q, vel_x_q, pos_y_q, pos_x_q};

endmodule

>>> rtl/core/rna_div.sv
`timescale 1ns / 1ps

module rna_div import rna_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  acc_t acc,
	output logic done,
	output entry_t mean
);

	localparam int LANES = 4;

	logic [STEP_W-1:0] step_q;
	logic done_q;
	logic [SUM_W-1:0] quo_q [LANES];
	logic [REM_W-1:0] rem_q [LANES];
	logic neg_q [LANES];

	sum_t lane_sum [LANES];
	logic [REM_W-1:0] div_ext;
	logic [REM_W-1:0] trial [LANES];
	logic [SUM_W-1:0] res [LANES];

	always_comb begin
		lane_sum[0] = acc.pos_x;
		lane_sum[1] = acc.pos_y;
		lane_sum[2] = acc.vel_x;
		lane_sum[3] = acc.vel_y;
		div_ext = {1'b0, acc.count};
		for (int l = 0; l < LANES; l++) begin
			trial[l] = {rem_q[l][REM_W-2:0], quo_q[l][SUM_W-1]};
			res[l] = neg_q[l] ? (~quo_q[l] + SUM_W'(1)) : quo_q[l];
		end
		mean.pos_x = res[0][DATA_W-1:0];
		mean.pos_y = res[1][DATA_W-1:0];
		mean.vel_x = res[2][DATA_W-1:0];
		mean.vel_y = res[3][DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == STEP_W'(1));
			if (start) begin
				step_q <= STEP_W'(SUM_W);
			end else if (step_q != '0) begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (start) begin
				neg_q[l] <= lane_sum[l][SUM_W-1];
				quo_q[l] <= lane_sum[l][SUM_W-1] ? (~lane_sum[l] + SUM_W'(1)) : lane_sum[l];
				rem_q[l] <= '0;
			end else if (step_q != '0) begin
				if (trial[l] >= div_ext) begin
					rem_q[l] <= trial[l] - div_ext;
					quo_q[l] <= {quo_q[l][SUM_W-2:0], 1'b1};
				end else begin
					rem_q[l] <= trial[l];
					quo_q[l] <= {quo_q[l][SUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;

endmodule
